FILE: hdl/adsd_pkg.sv
// ---------------------------------------------------------------------------
// adsd_pkg: shared types and constants for the A32 data-processing decoder
// Handler classes, flag bit positions, feature bits and the decoded record.
// ---------------------------------------------------------------------------
package adsd_pkg;

	localparam int unsigned FEAT_W  = 9;
	localparam int unsigned FLAGS_W = 9;

	// feature_mask bit positions
	localparam int unsigned FEAT_MOVW  = 0;
	localparam int unsigned FEAT_THUMB = 1;
	localparam int unsigned FEAT_CLZ   = 2;
	localparam int unsigned FEAT_BLX   = 3;
	localparam int unsigned FEAT_DSP   = 4;
	localparam int unsigned FEAT_SEC   = 5;
	localparam int unsigned FEAT_EXCL  = 6;
	localparam int unsigned FEAT_V6K   = 7;
	localparam int unsigned FEAT_V7    = 8;

	localparam logic [FEAT_W-1:0] FEAT_RESET = 9'h1FF;

	// flags bit positions
	localparam int unsigned FL_S      = 0;
	localparam int unsigned FL_PC     = 1;
	localparam int unsigned FL_ERET   = 2;
	localparam int unsigned FL_SYNC   = 3;
	localparam int unsigned FL_UNPRIV = 4;
	localparam int unsigned FL_LOAD   = 5;
	localparam int unsigned FL_WB     = 6;
	localparam int unsigned FL_UP     = 7;
	localparam int unsigned FL_PRE    = 8;

	// op1 row selects
	localparam logic [4:0] MISC_SPACE_MASK = 5'h19;
	localparam logic [4:0] MISC_SPACE_VAL  = 5'h10;
	localparam logic [4:0] OP1_MOVW        = 5'h10;
	localparam logic [4:0] OP1_MOVT        = 5'h14;
	localparam logic [4:0] EXCL_TOP        = 5'b00011;
	localparam logic [7:0] HINT_WFI        = 8'h03;

	// op2[2:0] groups of the miscellaneous space
	localparam logic [2:0] MISC_PSR    = 3'd0;
	localparam logic [2:0] MISC_BX_CLZ = 3'd1;
	localparam logic [2:0] MISC_BXJ    = 3'd2;
	localparam logic [2:0] MISC_BLX    = 3'd3;
	localparam logic [2:0] MISC_QARITH = 3'd5;
	localparam logic [2:0] MISC_EXC    = 3'd7;

	// bits 22:21 selectors inside those groups
	localparam logic [1:0] MOP_BRANCH = 2'd1;
	localparam logic [1:0] MOP_CLZ    = 2'd3;

	// exclusive access size in bytes, indexed by bits 22:21
	localparam logic [3:0] EXCL_BYTES [4] = '{4'd4, 4'd8, 4'd1, 4'd2};
	localparam logic [1:0] SZ_DOUBLE     = 2'd1;

	typedef enum logic [4:0] {
		HND_MUL     = 5'd0,
		HND_HALFMUL = 5'd1,
		HND_DPIMM   = 5'd2,
		HND_DPREG   = 5'd3,
		HND_DPSHREG = 5'd4,
		HND_MRSMSR  = 5'd5,
		HND_BX      = 5'd6,
		HND_CLZ     = 5'd7,
		HND_BLX     = 5'd8,
		HND_QARITH  = 5'd9,
		HND_UNIMPL  = 5'd10,
		HND_LDSTEXT = 5'd11,
		HND_LDREX   = 5'd12,
		HND_STREX   = 5'd13,
		HND_MOVW    = 5'd14,
		HND_MOVT    = 5'd15,
		HND_WFI     = 5'd16,
		HND_NOP     = 5'd17,
		HND_MSRIMM  = 5'd18
	} handler_t;

	// shift types in aux_field
	localparam logic [2:0] SHT_LSR = 3'd1;
	localparam logic [2:0] SHT_ASR = 3'd2;
	localparam logic [2:0] SHT_ROR = 3'd3;
	localparam logic [2:0] SHT_RRX = 3'd4;

	typedef struct packed {
		logic               valid_res;
		handler_t           handler;
		logic [3:0]         alu_op;
		logic [3:0]         reg_n;
		logic [3:0]         reg_d;
		logic [3:0]         reg_m;
		logic [5:0]         shift_or_rs;
		logic [2:0]         aux_field;
		logic [4:0]         reg_d2;
		logic [31:0]        immediate;
		logic [FLAGS_W-1:0] flags;
		logic [3:0]         psr_mask;
	} dec_rec_t;

endpackage

FILE: hdl/adsd_decode.sv
// ---------------------------------------------------------------------------
// adsd_decode: combinational decode of one A32 instruction word
// Splits the word into its row and forms the decoded record; rejected
// encodings give an all-zero record.
// ---------------------------------------------------------------------------
module adsd_decode (
	input  logic [31:0]                   instr,
	input  logic [adsd_pkg::FEAT_W-1:0]   feature_mask,
	output adsd_pkg::dec_rec_t            rec
);
	import adsd_pkg::*;

	logic [4:0]  op1;
	logic [3:0]  op2;
	logic [3:0]  opc;
	logic [3:0]  rn, rd, rm, rs;
	logic [1:0]  mop;
	logic        misc_space;
	logic        is_test, is_move;
	logic [4:0]  rot;
	logic [4:0]  imm5;
	logic [1:0]  sht;
	logic [1:0]  sz;
	logic [3:0]  nbytes;
	logic [4:0]  rt_inc;
	logic [7:0]  ls_imm8;
	logic        ls_dual;
	logic [63:0] rot_word;
	logic        ok;
	dec_rec_t    r;

	assign op1        = instr[24:20];
	assign op2        = instr[7:4];
	assign opc        = instr[24:21];
	assign rn         = instr[19:16];
	assign rd         = instr[15:12];
	assign rs         = instr[11:8];
	assign rm         = instr[3:0];
	assign mop        = instr[22:21];
	assign misc_space = (op1 & MISC_SPACE_MASK) == MISC_SPACE_VAL;
	assign is_test    = opc[3:2] == 2'b10;
	assign is_move    = (opc[3:2] == 2'b11) && opc[0];
	assign rot        = {instr[11:8], 1'b0};
	assign imm5       = instr[11:7];
	assign sht        = instr[6:5];
	assign sz         = instr[22:21];
	assign nbytes     = EXCL_BYTES[sz];
	assign rt_inc     = {1'b0, rm} + 5'd1;
	assign ls_imm8    = {instr[11:8], instr[3:0]};
	assign ls_dual    = !instr[20] && instr[6];
	// rotate right of imm8 by a doubled nibble
	assign rot_word = {24'd0, instr[7:0], 24'd0, instr[7:0]} >> rot;

	always_comb begin
		r  = '0;
		ok = 1'b0;
		if (!instr[25]) begin
			if (op2 == 4'h9) begin
				if (!op1[4]) begin
					r.handler = HND_MUL;
					ok = 1'b1;
				end else if (instr[23]) begin
					// exclusives
					ok = feature_mask[FEAT_EXCL] && (instr[27:23] == EXCL_TOP)
						&& (rs == 4'hF)
						&& (sz != 2'd0 ? feature_mask[FEAT_V6K] : 1'b1)
						&& rn != 4'hF && rd != 4'hF;
					r.alu_op = nbytes;
					r.reg_n  = rn;
					r.reg_d  = rd;
					if (instr[20]) begin
						if (rm != 4'hF) ok = 1'b0;
						if (sz == SZ_DOUBLE) begin
							if (rd[0] || rd == 4'd14) ok = 1'b0;
							r.reg_d2 = {1'b0, rd} + 5'd1;
						end
						r.handler = HND_LDREX;
					end else begin
						if (rm == 4'hF || rd == rm || rd == rn) ok = 1'b0;
						if (sz == SZ_DOUBLE) begin
							if (rm[0] || rm == 4'd14 || {1'b0, rd} == rt_inc) ok = 1'b0;
							r.reg_d2 = rt_inc;
						end
						r.handler = HND_STREX;
						r.reg_m   = rm;
					end
				end else begin
					// swap
					ok = ((instr[23:20] & 4'hB) == 4'h0) && (rs == 4'h0);
					r.handler   = HND_LDSTEXT;
					r.reg_n     = rn;
					r.reg_d     = rd;
					r.reg_m     = rm;
					r.aux_field = {2'b00, instr[22]};
					r.alu_op    = {2'b00, sht};
				end
			end else if (op2[3] && op2[0]) begin
				// extra load/store, offset formed for every form
				ok = 1'b1;
				r.handler   = HND_LDSTEXT;
				r.alu_op    = {2'b00, sht};
				r.aux_field = {2'b00, instr[22]};
				r.reg_n     = rn;
				r.reg_d     = rd;
				r.reg_m     = rm;
				r.reg_d2    = {1'b0, rd} + 5'd1;
				r.immediate = instr[23] ? {24'd0, ls_imm8} : 32'd0 - {24'd0, ls_imm8};
				r.flags[FL_LOAD]   = instr[20];
				r.flags[FL_WB]     = instr[21];
				r.flags[FL_UP]     = instr[23];
				r.flags[FL_PRE]    = instr[24];
				r.flags[FL_UNPRIV] = !ls_dual && !instr[24] && instr[21];
			end else if (misc_space) begin
				if (op2[3]) begin
					r.handler = HND_HALFMUL;
					ok = 1'b1;
				end else begin
					case (op2[2:0])
						MISC_PSR: begin
							ok = !instr[9];
							r.handler     = HND_MRSMSR;
							r.flags[FL_S] = mop[0];
							r.aux_field   = {2'b00, mop[1]};
							if (!mop[0]) begin
								r.reg_d = rd;
							end else begin
								r.reg_m          = rm;
								r.psr_mask       = rn;
								r.flags[FL_SYNC] = 1'b1;
							end
						end
						MISC_BX_CLZ: begin
							if (mop == MOP_BRANCH) begin
								ok = feature_mask[FEAT_THUMB];
								r.handler      = HND_BX;
								r.reg_m        = rm;
								r.flags[FL_PC] = 1'b1;
							end else if (mop == MOP_CLZ) begin
								ok = feature_mask[FEAT_CLZ] && rd != 4'hF && rm != 4'hF;
								r.handler = HND_CLZ;
								r.reg_d   = rd;
								r.reg_m   = rm;
							end
						end
						MISC_BXJ: begin
							ok = mop == MOP_BRANCH;
							r.handler = HND_UNIMPL;
						end
						MISC_BLX: begin
							ok = mop == MOP_BRANCH && feature_mask[FEAT_BLX] && rm != 4'hF;
							r.handler      = HND_BLX;
							r.reg_m        = rm;
							r.flags[FL_PC] = 1'b1;
						end
						MISC_QARITH: begin
							ok = feature_mask[FEAT_DSP] && rs == 4'h0
								&& rn != 4'hF && rd != 4'hF && rm != 4'hF;
							r.handler = HND_QARITH;
							r.alu_op  = {2'b00, mop};
							r.reg_n   = rn;
							r.reg_d   = rd;
							r.reg_m   = rm;
						end
						MISC_EXC: begin
							ok = mop == MOP_BRANCH || (mop == MOP_CLZ && feature_mask[FEAT_SEC]);
							r.handler = HND_UNIMPL;
						end
						default: ok = 1'b0;
					endcase
				end
			end else if (!op2[0]) begin
				// register operand with immediate shift
				ok = !(is_move && rn != 4'h0) && !(is_test && rd != 4'h0);
				r.handler     = HND_DPREG;
				r.alu_op      = opc;
				r.reg_n       = rn;
				r.reg_d       = rd;
				r.reg_m       = rm;
				r.aux_field   = {1'b0, sht};
				r.shift_or_rs = {1'b0, imm5};
				if (({1'b0, sht} == SHT_LSR || {1'b0, sht} == SHT_ASR) && imm5 == 5'd0)
					r.shift_or_rs = 6'd32;
				if ({1'b0, sht} == SHT_ROR && imm5 == 5'd0) begin
					r.aux_field   = SHT_RRX;
					r.shift_or_rs = 6'd1;
				end
				r.flags[FL_S]    = instr[20];
				r.flags[FL_PC]   = rd == 4'hF && !is_test;
				r.flags[FL_ERET] = rd == 4'hF && !is_test && instr[20];
			end else begin
				// register-shifted register
				ok = !(is_move && rn != 4'h0) && !(is_test && rd != 4'h0)
					&& rm != 4'hF && rs != 4'hF
					&& !(!is_test && rd == 4'hF) && !(!is_move && rn == 4'hF);
				r.handler     = HND_DPSHREG;
				r.alu_op      = opc;
				r.reg_n       = rn;
				r.reg_d       = rd;
				r.reg_m       = rm;
				r.shift_or_rs = {2'b00, rs};
				r.aux_field   = {1'b0, sht};
				r.flags[FL_S] = instr[20];
			end
		end else if (!misc_space) begin
			ok = !(is_move && rn != 4'h0) && !(is_test && rd != 4'h0);
			r.handler        = HND_DPIMM;
			r.alu_op         = opc;
			r.reg_n          = rn;
			r.reg_d          = rd;
			r.shift_or_rs    = {1'b0, rot};
			r.immediate      = rot_word[31:0];
			r.flags[FL_S]    = instr[20];
			r.flags[FL_PC]   = rd == 4'hF && !is_test;
			r.flags[FL_ERET] = rd == 4'hF && !is_test && instr[20];
		end else if (op1 == OP1_MOVW || op1 == OP1_MOVT) begin
			ok = feature_mask[FEAT_MOVW] && rd != 4'hF;
			r.handler   = (op1 == OP1_MOVW) ? HND_MOVW : HND_MOVT;
			r.reg_d     = rd;
			r.immediate = {16'd0, instr[19:16], instr[11:0]};
		end else begin
			ok = 1'b1;
			if (!instr[22] && rn == 4'h0 && feature_mask[FEAT_V7]) begin
				r.handler = (instr[7:0] == HINT_WFI) ? HND_WFI : HND_NOP;
			end else begin
				r.handler        = HND_MSRIMM;
				r.psr_mask       = rn;
				r.aux_field      = {2'b00, instr[22]};
				r.immediate      = {20'd0, instr[11:0]};
				r.flags[FL_SYNC] = 1'b1;
			end
		end

		if (ok) begin
			r.valid_res = 1'b1;
		end else begin
			r = '0;
		end
	end

	assign rec = r;

endmodule

FILE: hdl/arm_dataproc_space_decode.sv
// Path: a taken word is held in the input register, then its decoded record in the result register.
// Throughput: one word per cycle while the output is not stalled; input register, decode logic, result register.
// While a record waits on the output, one more word fills the empty input stage, then input stalls.
// Reset (arst_n low, asynchronous): both stages empty, feature_mask back to all ones.
// ---------------------------------------------------------------------------
// arm_dataproc_space_decode: A32 data-processing space decoder, top level
// Two-stage stream pipeline around the combinational decoder, plus the
// feature mask register.
// ---------------------------------------------------------------------------
module arm_dataproc_space_decode (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [adsd_pkg::FEAT_W-1:0]  cfg_data,       // feature_mask
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [31:0]                  s_axis_tdata,   // instr_word
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// alu_op[3:0] reg_n[7:4] reg_d[11:8] reg_m[15:12] shift_or_rs[21:16]
	// aux_field[24:22] reg_d2[29:25] immediate[61:30] flags[70:62]
	// psr_mask[74:71], zero pad [79:75]
	output logic [79:0]                  m_axis_tdata,
	output logic [5:0]                   m_axis_tuser    // valid_res[0] handler[5:1]
);
	import adsd_pkg::*;

	logic [FEAT_W-1:0] feature_mask_q;
	logic              valid_s1;
	logic [31:0]       instr_s1;
	logic              valid_s2;
	dec_rec_t          rec_s2;
	dec_rec_t          dec_rec;
	logic              adv_s2;
	logic              adv_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feature_mask_q <= FEAT_RESET;
		end else if (cfg_valid) begin
			feature_mask_q <= cfg_data;
		end
	end

	adsd_decode u_decode (
		.instr        (instr_s1),
		.feature_mask (feature_mask_q),
		.rec          (dec_rec)
	);

	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= s_axis_tvalid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) instr_s1 <= s_axis_tdata;
		if (adv_s2 && valid_s1) rec_s2 <= dec_rec;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = {rec_s2.handler, rec_s2.valid_res};
	assign m_axis_tdata  = {5'd0, rec_s2.psr_mask, rec_s2.flags, rec_s2.immediate,
		rec_s2.reg_d2, rec_s2.aux_field, rec_s2.shift_or_rs, rec_s2.reg_m,
		rec_s2.reg_d, rec_s2.reg_n, rec_s2.alu_op};

`ifndef SYNTHESIS
	// a rejected encoding carries an all-zero record
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 80'd0 && m_axis_tuser == 6'd0))
		else $error("rejected encoding with non-zero fields");

	// an empty output register never blocks the input
	a_no_bubble_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output stage");

	// a word held in the input stage is not dropped while the output is stalled
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s2) |=> (valid_s1 && $stable(instr_s1)))
		else $error("input stage lost its word under stall");
`endif

endmodule

FILE: verif/adsd_record_checker.sv
// ---------------------------------------------------------------------------
// adsd_record_checker: decoded-record checker for arm_dataproc_space_decode
// Watches the configuration, instruction and record channels, decodes every
// accepted instruction word against its own copy of the feature mask and
// compares each record leaving the block with the oldest one still due.
// ---------------------------------------------------------------------------
module adsd_record_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [adsd_pkg::FEAT_W-1:0] cfg_data,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [31:0]                 s_tdata,
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [79:0]                 m_tdata,
	input  logic [5:0]                  m_tuser,
	output int                          fail_count,
	output int                          records_due
);
	import adsd_pkg::*;

	localparam int MAX_PRINTED = 40;

	logic [FEAT_W-1:0] feature_copy;
	dec_rec_t          expected_recs [$];
	dec_rec_t          seen;
	int                mismatches = 0;

	assign fail_count = mismatches;

	always_comb begin
		seen.valid_res   = m_tuser[0];
		seen.handler     = handler_t'(m_tuser[5:1]);
		seen.alu_op      = m_tdata[3:0];
		seen.reg_n       = m_tdata[7:4];
		seen.reg_d       = m_tdata[11:8];
		seen.reg_m       = m_tdata[15:12];
		seen.shift_or_rs = m_tdata[21:16];
		seen.aux_field   = m_tdata[24:22];
		seen.reg_d2      = m_tdata[29:25];
		seen.immediate   = m_tdata[61:30];
		seen.flags       = m_tdata[70:62];
		seen.psr_mask    = m_tdata[74:71];
	end

	function automatic dec_rec_t decode_a32_word(input logic [31:0] w,
			input logic [FEAT_W-1:0] fm);
		dec_rec_t    r;
		logic [4:0]  op1;
		logic [3:0]  op2, opc, rn, rd, rm, rs;
		logic [1:0]  mop, sht;
		logic [4:0]  imm5, rot;
		logic [7:0]  imm8;
		logic [63:0] rot_pair;
		logic        s, tst, mv, misc_space, dual;
		r = '0;
		op1 = w[24:20];
		op2 = w[7:4];
		opc = w[24:21];
		s = w[20];
		rn = w[19:16];
		rd = w[15:12];
		rm = w[3:0];
		rs = w[11:8];
		mop = w[22:21];
		sht = w[6:5];
		imm5 = w[11:7];
		tst = (opc[3:2] == 2'b10);           // TST TEQ CMP CMN
		mv = (opc[3:2] == 2'b11) && opc[0];   // MOV MVN
		misc_space = (op1 & MISC_SPACE_MASK) == MISC_SPACE_VAL;
		r.valid_res = 1'b1;

		if (w[25]) begin
			if (!misc_space) begin
				if ((mv && rn != 4'h0) || (tst && rd != 4'h0))
					return '0;
				rot = {rs, 1'b0};
				rot_pair = {24'd0, w[7:0], 24'd0, w[7:0]} >> rot;
				r.handler = HND_DPIMM;
				r.alu_op = opc;
				r.reg_n = rn;
				r.reg_d = rd;
				r.shift_or_rs = {1'b0, rot};
				r.immediate = rot_pair[31:0];
				r.flags[FL_S] = s;
				if (rd == 4'hF && !tst) begin
					r.flags[FL_PC] = 1'b1;
					r.flags[FL_ERET] = s;
				end
				return r;
			end
			if (op1 == OP1_MOVW || op1 == OP1_MOVT) begin
				if (!fm[FEAT_MOVW] || rd == 4'hF)
					return '0;
				r.handler = (op1 == OP1_MOVW) ? HND_MOVW : HND_MOVT;
				r.reg_d = rd;
				r.immediate = {16'd0, rn, w[11:0]};
				return r;
			end
			// hints only when CPSR is selected with an empty field mask
			if (!w[22] && rn == 4'h0 && fm[FEAT_V7]) begin
				r.handler = (w[7:0] == HINT_WFI) ? HND_WFI : HND_NOP;
				return r;
			end
			r.handler = HND_MSRIMM;
			r.psr_mask = rn;
			r.aux_field = {2'b00, w[22]};
			r.immediate = {20'd0, w[11:0]};
			r.flags[FL_SYNC] = 1'b1;
			return r;
		end

		if (op2 == 4'h9) begin
			if (!op1[4]) begin
				r.handler = HND_MUL;
				return r;
			end
			if (w[23]) begin
				// exclusives: on stores rt sits in bits 3:0 and rd is the status register
				if (!fm[FEAT_EXCL] || w[27:23] != EXCL_TOP || rs != 4'hF)
					return '0;
				if (mop != 2'd0 && !fm[FEAT_V6K])
					return '0;
				if (rn == 4'hF || rd == 4'hF)
					return '0;
				r.alu_op = EXCL_BYTES[mop];
				r.reg_n = rn;
				r.reg_d = rd;
				if (w[20]) begin
					if (rm != 4'hF)
						return '0;
					if (mop == SZ_DOUBLE) begin
						if (rd[0] || rd == 4'hE)
							return '0;
						r.reg_d2 = {1'b0, rd} + 5'd1;
					end
					r.handler = HND_LDREX;
					return r;
				end
				if (rm == 4'hF || rd == rm || rd == rn)
					return '0;
				if (mop == SZ_DOUBLE) begin
					if (rm[0] || rm == 4'hE || rd == rm + 4'd1)
						return '0;
					r.reg_d2 = {1'b0, rm} + 5'd1;
				end
				r.handler = HND_STREX;
				r.reg_m = rm;
				return r;
			end
			// swap
			if (w[21] || w[20] || rs != 4'h0)
				return '0;
			r.handler = HND_LDSTEXT;
			r.reg_n = rn;
			r.reg_d = rd;
			r.reg_m = rm;
			r.aux_field = {2'b00, w[22]};
			r.alu_op = {2'b00, sht};
			return r;
		end

		if (w[7] && w[4]) begin
			// extra load/store; offset formed for register forms as well
			dual = !w[20] && w[6];
			imm8 = {w[11:8], w[3:0]};
			r.handler = HND_LDSTEXT;
			r.alu_op = {2'b00, sht};
			r.aux_field = {2'b00, w[22]};
			r.reg_n = rn;
			r.reg_d = rd;
			r.reg_m = rm;
			r.reg_d2 = {1'b0, rd} + 5'd1;
			r.immediate = w[23] ? {24'd0, imm8} : 32'd0 - {24'd0, imm8};
			r.flags[FL_LOAD] = w[20];
			r.flags[FL_WB] = w[21];
			r.flags[FL_UP] = w[23];
			r.flags[FL_PRE] = w[24];
			r.flags[FL_UNPRIV] = !dual && !w[24] && w[21];
			return r;
		end

		if (misc_space) begin
			if (op2[3]) begin
				r.handler = HND_HALFMUL;
				return r;
			end
			case (op2[2:0])
				MISC_PSR: begin
					if (w[9])
						return '0;
					r.handler = HND_MRSMSR;
					r.flags[FL_S] = mop[0];
					r.aux_field = {2'b00, mop[1]};
					if (!mop[0]) begin
						r.reg_d = rd;
					end else begin
						r.reg_m = rm;
						r.psr_mask = rn;
						r.flags[FL_SYNC] = 1'b1;
					end
					return r;
				end
				MISC_BX_CLZ: begin
					if (mop == MOP_BRANCH && fm[FEAT_THUMB]) begin
						r.handler = HND_BX;
						r.reg_m = rm;
						r.flags[FL_PC] = 1'b1;
						return r;
					end
					if (mop == MOP_CLZ && fm[FEAT_CLZ] && rd != 4'hF && rm != 4'hF) begin
						r.handler = HND_CLZ;
						r.reg_d = rd;
						r.reg_m = rm;
						return r;
					end
					return '0;
				end
				MISC_BXJ: begin
					if (mop != MOP_BRANCH)
						return '0;
					r.handler = HND_UNIMPL;
					return r;
				end
				MISC_BLX: begin
					if (mop != MOP_BRANCH || !fm[FEAT_BLX] || rm == 4'hF)
						return '0;
					r.handler = HND_BLX;
					r.reg_m = rm;
					r.flags[FL_PC] = 1'b1;
					return r;
				end
				MISC_QARITH: begin
					if (!fm[FEAT_DSP] || rs != 4'h0)
						return '0;
					if (rn == 4'hF || rd == 4'hF || rm == 4'hF)
						return '0;
					r.handler = HND_QARITH;
					r.alu_op = {2'b00, mop};
					r.reg_n = rn;
					r.reg_d = rd;
					r.reg_m = rm;
					return r;
				end
				MISC_EXC: begin
					// BKPT always, SMC only with the security extensions
					if (mop == MOP_BRANCH || (mop == MOP_CLZ && fm[FEAT_SEC])) begin
						r.handler = HND_UNIMPL;
						return r;
					end
					return '0;
				end
				default: return '0;
			endcase
		end

		if ((mv && rn != 4'h0) || (tst && rd != 4'h0))
			return '0;
		r.alu_op = opc;
		r.reg_n = rn;
		r.reg_d = rd;
		r.reg_m = rm;
		r.aux_field = {1'b0, sht};
		r.flags[FL_S] = s;
		if (!op2[0]) begin
			// DecodeImmShift: zero amount means 32 for LSR/ASR and RRX for ROR
			r.handler = HND_DPREG;
			r.shift_or_rs = {1'b0, imm5};
			if (imm5 == 5'd0) begin
				if (r.aux_field == SHT_LSR || r.aux_field == SHT_ASR) begin
					r.shift_or_rs = 6'd32;
				end else if (r.aux_field == SHT_ROR) begin
					r.aux_field = SHT_RRX;
					r.shift_or_rs = 6'd1;
				end
			end
			if (rd == 4'hF && !tst) begin
				r.flags[FL_PC] = 1'b1;
				r.flags[FL_ERET] = s;
			end
			return r;
		end
		if (rm == 4'hF || rs == 4'hF || (!tst && rd == 4'hF) || (!mv && rn == 4'hF))
			return '0;
		r.handler = HND_DPSHREG;
		r.shift_or_rs = {2'b00, rs};
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		// keep counting once the log has enough to go on
		if (mismatches < MAX_PRINTED)
			$display("[%0t] record mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
	endtask

	task automatic compare_record(input dec_rec_t want, input dec_rec_t got);
		check_field("valid_res", got.valid_res, want.valid_res);
		check_field("handler", got.handler, want.handler);
		check_field("alu_op", got.alu_op, want.alu_op);
		check_field("reg_n", got.reg_n, want.reg_n);
		check_field("reg_d", got.reg_d, want.reg_d);
		check_field("reg_m", got.reg_m, want.reg_m);
		check_field("shift_or_rs", got.shift_or_rs, want.shift_or_rs);
		check_field("aux_field", got.aux_field, want.aux_field);
		check_field("reg_d2", got.reg_d2, want.reg_d2);
		check_field("immediate", got.immediate, want.immediate);
		check_field("flags", got.flags, want.flags);
		check_field("psr_mask", got.psr_mask, want.psr_mask);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feature_copy <= FEAT_RESET;
			expected_recs.delete();
			records_due <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_recs.size() == 0)
					report_mismatch("record transaction with nothing due");
				else
					compare_record(expected_recs.pop_front(), seen);
			end
			if (s_tvalid && s_tready)
				expected_recs.push_back(decode_a32_word(s_tdata, feature_copy));
			if (cfg_valid && cfg_ready)
				feature_copy <= cfg_data;
			records_due <= expected_recs.size();
		end
	end

endmodule

FILE: verif/tb_arm_dataproc_space_decode.sv
// ---------------------------------------------------------------------------
// tb_arm_dataproc_space_decode: testbench top for the A32 decoder
// Feeds a directed set of encodings, then biased random instruction words
// under several feature masks, with bursty input and a stalling output.
// The record checker beside the block does prediction and comparison.
// ---------------------------------------------------------------------------
module tb_arm_dataproc_space_decode;
	import adsd_pkg::*;

	localparam int unsigned WORDS_PER_PHASE = 325;
	localparam int unsigned MASK_PHASES     = 6;
	localparam int unsigned HOLD_CYCLES     = 120;

	localparam logic [31:0] DIRECTED [26] = '{
		32'h00000000, 32'hFFFFFFFF, 32'hE3B0F2FF, 32'hE1A00020, 32'hE1A00060,
		32'hE0810312, 32'hE151F000, 32'hE0000091, 32'hE1401090, 32'hE1B10F9F,
		32'hE1A02F94, 32'hE1A05F94, 32'hE0F000B0, 32'hE1510FBF, 32'hE06000F0,
		32'hE14F0000, 32'hE129F000, 32'hE12FFF1E, 32'hE16F0F11, 32'hE12FFF31,
		32'hE1010050, 32'hE1600070, 32'hE1000080, 32'hE3412345, 32'hE320F003,
		32'hE36FF0FF
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [FEAT_W-1:0] cfg_data = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [31:0]       s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [79:0]       m_axis_tdata;
	logic [5:0]        m_axis_tuser;
	int                fail_count;
	int                records_due;
	logic              hold_go = 1'b0;
	int unsigned       burst_left = 0;

	always #2 clk = ~clk;

	arm_dataproc_space_decode u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	adsd_record_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_axis_tvalid),
		.s_tready    (s_axis_tready),
		.s_tdata     (s_axis_tdata),
		.m_tvalid    (m_axis_tvalid),
		.m_tready    (m_axis_tready),
		.m_tdata     (m_axis_tdata),
		.m_tuser     (m_axis_tuser),
		.fail_count  (fail_count),
		.records_due (records_due)
	);

	initial begin : watchdog
		#800000;
		$display("arm_dataproc_space_decode verification failed");
		$finish;
	end

	// record side: stall pattern redrawn from four modes after each random-length run, one long hold-off
	initial begin : record_sink
		int unsigned mode;
		int unsigned left;
		int unsigned tick;
		bit          held;
		mode = 0;
		left = 0;
		tick = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_go && !held) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(8, 64);
				end
				left--;
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= (tick % 3) == 0;
					default: m_axis_tready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	function automatic logic [3:0] pick_reg();
		// lean on r15 and the low registers so the overlap rules get exercised
		case ($urandom_range(0, 3))
			0: return 4'hF;
			1: return 4'($urandom_range(0, 3));
			default: return 4'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] random_a32_word();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(0, 9))
			0, 1: ;
			2: w[27:25] = 3'b001;
			3: w[27:25] = 3'b000;
			4: begin
				w[27:23] = EXCL_TOP;
				w[11:4] = 8'hF9;
				w[19:16] = pick_reg();
				w[15:12] = pick_reg();
				w[3:0] = (w[20] && $urandom_range(0, 3) != 0) ? 4'hF : pick_reg();
			end
			5: begin
				w[27:20] = {5'b00010, w[22], 2'b00};
				w[7:4] = 4'h9;
				if ($urandom_range(0, 3) != 0)
					w[11:8] = 4'h0;
			end
			6: begin
				w[27:25] = 3'b000;
				w[7] = 1'b1;
				w[4] = 1'b1;
				if (w[6:5] == 2'b00)
					w[6:5] = 2'($urandom_range(1, 3));
			end
			7: begin
				w[27:23] = 5'b00010;
				w[20] = 1'b0;
				w[7] = 1'b0;
				w[19:16] = pick_reg();
				w[15:12] = pick_reg();
				w[3:0] = pick_reg();
				if ($urandom_range(0, 2) != 0)
					w[11:8] = $urandom_range(0, 1) ? 4'h0 : 4'hF;
			end
			8: begin
				w[27:23] = 5'b00110;
				w[20] = 1'b0;
				if ($urandom_range(0, 1)) begin
					w[19:16] = 4'h0;
					w[22] = 1'b0;
				end
				if ($urandom_range(0, 2) == 0)
					w[7:0] = HINT_WFI;
			end
			default: begin
				w[27:26] = 2'b00;
				w[19:16] = pick_reg();
				w[15:12] = pick_reg();
				w[3:0] = pick_reg();
				if ($urandom_range(0, 2) == 0)
					w[11:7] = 5'd0;
			end
		endcase
		return w;
	endfunction

	task automatic send_word(input logic [31:0] w);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= w;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (records_due != 0) @(posedge clk);
	endtask

	task automatic write_features(input logic [FEAT_W-1:0] mask);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= mask;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [FEAT_W-1:0] mask_plan [MASK_PHASES];
		mask_plan[0] = '0;
		mask_plan[1] = FEAT_RESET;
		for (int i = 2; i < MASK_PHASES; i++)
			mask_plan[i] = FEAT_W'($urandom_range(0, 511));
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset mask still in force for the directed encodings
		foreach (DIRECTED[i])
			send_word(DIRECTED[i]);
		for (int p = 0; p < MASK_PHASES; p++) begin
			write_features(mask_plan[p]);
			if (p == 1)
				hold_go = 1'b1;
			repeat (WORDS_PER_PHASE)
				send_word(random_a32_word());
		end
		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("arm_dataproc_space_decode verification clean");
		else
			$display("arm_dataproc_space_decode verification failed");
		$finish;
	end

endmodule
